// ===== sv/dwbm_pkg.sv =====
// Shared constants, command and status types for the dual window block mean core.
`default_nettype none

package dwbm_pkg;

  localparam int SAMPLE_BITS  = 32;
  localparam int WINDOW_BITS  = 8;
  localparam int SUM_BITS     = SAMPLE_BITS + WINDOW_BITS;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
  localparam int INDEX_BITS   = 1;

  // Configuration register indexes.
  localparam logic [INDEX_BITS-1:0] REG_FIRST_WINDOW  = 1'b0;
  localparam logic [INDEX_BITS-1:0] REG_SECOND_WINDOW = 1'b1;

  // Averager select codes.
  localparam logic SEL_FIRST  = 1'b0;
  localparam logic SEL_SECOND = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the input request into both accumulators
    logic div_start;  // load the divider from the selected snapshot
    logic div_sel;    // averager whose block is divided
    logic out_load;   // move the quotient into the output register
    logic out_last;   // final result of this request
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done_first;   // first averager closed a block on the last request
    logic done_second;  // second averager closed a block on the last request
    logic div_busy;     // divider is iterating
    logic out_free;     // output register can be loaded this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== sv/dwbm_ctrl.sv =====
// Controller state machine that sequences accumulation, division and result hand-off.
`default_nettype none

module dwbm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dwbm_pkg::status_t st,
  output dwbm_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   sel;
  logic   sel_next;

  always_comb begin
    state_next    = state;
    sel_next      = sel;
    cmd           = '0;
    cmd.div_sel   = sel;
    in_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.done_first) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = dwbm_pkg::SEL_FIRST;
          sel_next      = dwbm_pkg::SEL_FIRST;
          state_next    = S_DIV;
        end else if (st.done_second) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = dwbm_pkg::SEL_SECOND;
          sel_next      = dwbm_pkg::SEL_SECOND;
          state_next    = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (!st.div_busy) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (sel == dwbm_pkg::SEL_SECOND) || !st.done_second;
          if ((sel == dwbm_pkg::SEL_FIRST) && st.done_second) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = dwbm_pkg::SEL_SECOND;
            sel_next      = dwbm_pkg::SEL_SECOND;
            state_next    = S_DIV;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= dwbm_pkg::SEL_FIRST;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

`ifndef ASSERT_OFF
  // No new request may enter while a division is still running.
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    st.div_busy |-> !in_ready)
    else $error("request taken while divider busy");

  // A result that is not the last one must be followed by the second division.
  a_not_last_starts_second: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && !cmd.out_last) |-> (cmd.div_start && cmd.div_sel == dwbm_pkg::SEL_SECOND))
    else $error("non-final result without a following division");

  // A request is only taken into the accumulators on a handshake.
  a_accept_on_handshake: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> (in_valid && in_ready))
    else $error("request taken without a handshake");
`endif

endmodule

`default_nettype wire

// ===== sv/dwbm_datapath.sv =====
// Datapath: window registers, two accumulators, shared restoring divider, output register.
`default_nettype none

module dwbm_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [dwbm_pkg::INDEX_BITS-1:0]      cfg_index,
  input  wire logic [dwbm_pkg::WINDOW_BITS-1:0]     cfg_data,
  input  wire logic [dwbm_pkg::SAMPLE_BITS-1:0]     sample,
  input  wire logic                                 end_of_series,
  input  wire dwbm_pkg::cmd_t                       cmd,
  output dwbm_pkg::status_t                         st,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      which_window,
  output logic [dwbm_pkg::SAMPLE_BITS-1:0]          mean,
  output logic                                      last
);

  localparam int SB = dwbm_pkg::SAMPLE_BITS;
  localparam int WB = dwbm_pkg::WINDOW_BITS;
  localparam int MB = dwbm_pkg::SUM_BITS;
  localparam int CB = dwbm_pkg::DIV_CNT_BITS;

  logic [WB-1:0] first_window;
  logic [WB-1:0] second_window;
  logic [WB-1:0] first_eff;
  logic [WB-1:0] second_eff;

  logic [WB-1:0] first_count;
  logic [MB-1:0] first_sum;
  logic [WB-1:0] second_count;
  logic [MB-1:0] second_sum;
  logic [MB-1:0] first_snap;
  logic [MB-1:0] second_snap;
  logic          first_done;
  logic          second_done;

  logic [WB-1:0] first_count_next;
  logic [MB-1:0] first_sum_next;
  logic [WB-1:0] second_count_next;
  logic [MB-1:0] second_sum_next;
  logic          first_hit;
  logic          second_hit;

  logic [MB-1:0] quo;
  logic [WB-1:0] rem;
  logic [WB-1:0] den;
  logic          div_owner;
  logic [CB-1:0] div_cnt;
  logic          div_busy;
  logic [WB:0]   rem_shift;
  logic [WB-1:0] rem_diff;
  logic          q_bit;
  logic [SB-1:0] quo_sat;

  // A zero window behaves as a window of one.
  assign first_eff  = (first_window  == '0) ? WB'(1) : first_window;
  assign second_eff = (second_window == '0) ? WB'(1) : second_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_window  <= WB'(1);
      second_window <= WB'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        dwbm_pkg::REG_FIRST_WINDOW:  first_window  <= cfg_data;
        dwbm_pkg::REG_SECOND_WINDOW: second_window <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Accumulate the sample into both averagers; a block closes when the count
  // reaches the current window.
  assign first_sum_next    = first_sum + MB'(sample);
  assign first_count_next  = first_count + WB'(1);
  assign first_hit         = first_count_next >= first_eff;
  assign second_sum_next   = second_sum + MB'(sample);
  assign second_count_next = second_count + WB'(1);
  assign second_hit        = second_count_next >= second_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      first_sum    <= '0;
      second_count <= '0;
      second_sum   <= '0;
      first_done   <= 1'b0;
      second_done  <= 1'b0;
    end else if (cmd.accept) begin
      first_done  <= first_hit;
      second_done <= second_hit;
      if (end_of_series || first_hit) begin
        first_count <= '0;
        first_sum   <= '0;
      end else begin
        first_count <= first_count_next;
        first_sum   <= first_sum_next;
      end
      if (end_of_series || second_hit) begin
        second_count <= '0;
        second_sum   <= '0;
      end else begin
        second_count <= second_count_next;
        second_sum   <= second_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      first_snap  <= first_sum_next;
      second_snap <= second_sum_next;
    end
  end

  // Restoring divider, one quotient bit per cycle, MSB first. The partial
  // remainder stays below the divisor, so the difference fits the window width.
  assign rem_shift = {rem, quo[MB-1]};
  assign rem_diff  = rem_shift[WB-1:0] - den;
  assign q_bit     = rem_shift >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= CB'(MB);
    end else if (div_busy) begin
      div_cnt <= div_cnt - CB'(1);
      if (div_cnt == CB'(1)) begin
        div_busy <= 1'b0;
      end
    end
  end

  // The averager that owns the running division is kept with the quotient.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo       <= (cmd.div_sel == dwbm_pkg::SEL_SECOND) ? second_snap : first_snap;
      den       <= (cmd.div_sel == dwbm_pkg::SEL_SECOND) ? second_eff : first_eff;
      div_owner <= cmd.div_sel;
      rem       <= '0;
    end else if (div_busy) begin
      quo <= {quo[MB-2:0], q_bit};
      rem <= q_bit ? rem_diff : rem_shift[WB-1:0];
    end
  end

  // Quotients beyond the sample range saturate.
  assign quo_sat = (quo[MB-1:SB] != '0) ? '1 : quo[SB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      which_window <= div_owner;
      mean         <= quo_sat;
      last         <= cmd.out_last;
    end
  end

  assign st.done_first  = first_done;
  assign st.done_second = second_done;
  assign st.div_busy    = div_busy;
  assign st.out_free    = !out_valid || out_ready;

`ifndef ASSERT_OFF
  // The output register is only loaded when its previous result has left.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // A division starts only on an idle divider and then runs.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (!div_busy ##1 div_busy))
    else $error("divider restarted while busy");

  // The quotient is never handed off in the middle of a division.
  a_load_not_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !div_busy)
    else $error("result loaded before division finished");
`endif

endmodule

`default_nettype wire

// ===== sv/dual_window_block_mean_core.sv =====
// Top level of the dual window block mean core: two decimating boxcar averagers.
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_ready    sample, end_of_series
// out       result     out_valid / out_ready  which_window, mean, last
// cfg       write      cfg_write (no wait)    cfg_index, cfg_data
//
// A request that closes no block passes the check state before the next one is taken.
// Each closed block runs through a check or load state, 40 iterations of the shared
// restoring divider and a final step in which the controller sees the divider finish; a
// request that closes both blocks runs through this sequence twice.
// The single divider works one quotient bit per cycle over the 40 bit sum.
// Reset is synchronous and needs no clearing pass; the core takes requests right after it.
// A stalled result stays in the output register; the next request is taken while it waits.
//
// Every request is added to both averagers. When an averager's count reaches its window,
// the block sum is snapshotted and divided by the window; the quotient, saturated to the
// sample range, is the result. If both averagers close a block on the same request, the
// first averager's result is delivered first, and last marks the final result of the
// request. A request flagged end_of_series discards both partial blocks after it is
// taken. A zero window acts as a window of one.

module dual_window_block_mean_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [dwbm_pkg::INDEX_BITS-1:0]      cfg_index,
  input  wire logic [dwbm_pkg::WINDOW_BITS-1:0]     cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [dwbm_pkg::SAMPLE_BITS-1:0]     sample,
  input  wire logic                                 end_of_series,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      which_window,
  output logic [dwbm_pkg::SAMPLE_BITS-1:0]          mean,
  output logic                                      last
);

  dwbm_pkg::cmd_t    cmd;
  dwbm_pkg::status_t st;

  // The controller sequences one request at a time through the shared divider.
  dwbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the windows, accumulators, divider and output register.
  dwbm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        (sample),
    .end_of_series (end_of_series),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .which_window  (which_window),
    .mean          (mean),
    .last          (last)
  );

endmodule

`default_nettype wire

// ===== bench/tb_dual_window_block_mean_core.sv =====
// Self-checking testbench for the dual window block mean core with a built-in averager predictor.

module tb_dual_window_block_mean_core;

  localparam int SAMPLE_BITS = dwbm_pkg::SAMPLE_BITS;
  localparam int WINDOW_BITS = dwbm_pkg::WINDOW_BITS;
  localparam int INDEX_BITS  = dwbm_pkg::INDEX_BITS;
  localparam int SUM_BITS    = dwbm_pkg::SUM_BITS;

  // The watchdog allows this many cycles in which no request and no result is accepted.
  // The slowest correct request closes both blocks, and each of its two results may wait
  // out the longest receiver stall. Add the longest sender gap and the drain pause, and
  // the true worst case stays well under this limit.
  localparam int STALL_LIMIT  = 4000;
  // Cycles to wait after the last expected result before a register write. A request
  // that closes no block finishes well within this wait; this also covers one full divide.
  localparam int DRAIN_CYCLES = 100;
  localparam logic [SAMPLE_BITS-1:0] MAX_SAMPLE = '1;

  // One result as the core should deliver it.
  typedef struct packed {
    logic                   which_window;
    logic [SAMPLE_BITS-1:0] mean;
    logic                   last;
  } block_mean_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_write     = 1'b0;
  logic [INDEX_BITS-1:0]  cfg_index     = '0;
  logic [WINDOW_BITS-1:0] cfg_data      = '0;
  logic                   in_valid      = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] sample        = '0;
  logic                   end_of_series = 1'b0;
  logic                   out_valid;
  logic                   out_ready     = 1'b0;
  logic                   which_window;
  logic [SAMPLE_BITS-1:0] mean;
  logic                   last;

  // Predictor state: the window registers and both running blocks, index 0 is the first
  // averager and index 1 the second.
  logic [WINDOW_BITS-1:0] win_len [2];
  logic [WINDOW_BITS-1:0] blk_cnt [2];
  logic [SUM_BITS-1:0]    blk_sum [2];

  // Means still owed by the core, oldest first.
  block_mean_t pending_means[$];

  int  mismatches     = 0;
  int  requests_sent  = 0;
  int  means_checked  = 0;
  int  saturated      = 0;
  int  settings_used  = 0;
  int  idle_cycles    = 0;
  int  stall_left     = 0;
  // While quiet is set neither side starts new gaps, so the core runs at full rate.
  bit  quiet          = 1'b0;

  dual_window_block_mean_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .end_of_series(end_of_series),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .which_window (which_window),
    .mean         (mean),
    .last         (last)
  );

  always #6 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample values lean on the extremes so that sums near the top of the range show up often.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: return '0;
      1: return MAX_SAMPLE;
      2: return {4'hF, 28'($urandom)};
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Adds one sample to averager k. Returns 1 with the block mean when the block closes.
  // A zero window counts as one, a block closes as soon as its count reaches the current
  // window, and a quotient beyond the sample range saturates.
  function automatic logic fold_in(input int k, input logic [SAMPLE_BITS-1:0] s,
                                   output logic [SAMPLE_BITS-1:0] avg);
    logic [SUM_BITS-1:0] divisor;
    logic [SUM_BITS-1:0] quot;
    avg = '0;
    divisor = {{(SUM_BITS-WINDOW_BITS){1'b0}}, win_len[k]};
    if (divisor == '0) divisor = SUM_BITS'(1);
    blk_sum[k] = blk_sum[k] + {{WINDOW_BITS{1'b0}}, s};
    blk_cnt[k] = blk_cnt[k] + 1'b1;
    if ({{(SUM_BITS-WINDOW_BITS){1'b0}}, blk_cnt[k]} < divisor) return 1'b0;
    quot = blk_sum[k] / divisor;
    if (quot > {{WINDOW_BITS{1'b0}}, MAX_SAMPLE}) begin
      avg = MAX_SAMPLE;
      saturated++;
    end else begin
      avg = quot[SAMPLE_BITS-1:0];
    end
    blk_cnt[k] = '0;
    blk_sum[k] = '0;
    return 1'b1;
  endfunction

  // Works out the means that one accepted request causes and queues them in order.
  function automatic void predict_request(input logic [SAMPLE_BITS-1:0] s, input logic eos);
    block_mean_t found [2];
    logic [SAMPLE_BITS-1:0] avg;
    int n;
    n = 0;
    if (fold_in(0, s, avg)) begin
      found[n] = '{which_window: dwbm_pkg::SEL_FIRST, mean: avg, last: 1'b0};
      n++;
    end
    if (fold_in(1, s, avg)) begin
      found[n] = '{which_window: dwbm_pkg::SEL_SECOND, mean: avg, last: 1'b0};
      n++;
    end
    for (int i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      pending_means.insert(pending_means.size(), found[i]);
    end
    // The end of a series throws away both partial blocks after the sample is taken.
    if (eos) begin
      for (int k = 0; k < 2; k++) begin
        blk_cnt[k] = '0;
        blk_sum[k] = '0;
      end
    end
  endfunction

  // Offers one request, waits for it to be taken, predicts it, then idles at random.
  // Valid is only lowered when a gap follows, so it never drops and rises in one step.
  task automatic send_request(input logic [SAMPLE_BITS-1:0] s, input logic eos);
    int gap;
    in_valid      <= 1'b1;
    sample        <= s;
    end_of_series <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(s, eos);
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering requests and waits until every owed mean has come back, then lets the
  // core finish any request that closed no block.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write. The write enable stays high for the caller to lower.
  task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [WINDOW_BITS-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    if (idx == dwbm_pkg::REG_FIRST_WINDOW) win_len[0] = v;
    else                                   win_len[1] = v;
  endtask

  // Sets both windows while the core is idle. The running blocks are kept on purpose.
  task automatic set_windows(input logic [WINDOW_BITS-1:0] first_len,
                             input logic [WINDOW_BITS-1:0] second_len);
    drain();
    write_reg(dwbm_pkg::REG_FIRST_WINDOW, first_len);
    write_reg(dwbm_pkg::REG_SECOND_WINDOW, second_len);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Right after reset both windows are one, so every request yields two means.
  task automatic test_reset_windows();
    send_request('0, 1'b0);
    send_request(MAX_SAMPLE, 1'b0);
    send_request(32'h8000_0000, 1'b1);
    send_request(32'h0000_0001, 1'b0);
  endtask

  // A zero window behaves as a window of one.
  task automatic test_zero_window();
    set_windows(8'd0, 8'd3);
    send_request(32'h1234_5678, 1'b0);
    send_request(MAX_SAMPLE, 1'b0);
    send_request(32'h0001_0000, 1'b1);
  endtask

  // The end of a series emits what it closes and drops the other partial block.
  task automatic test_end_of_series();
    set_windows(8'd3, 8'd2);
    send_request(32'h0003_0000, 1'b0);
    send_request(32'h0005_8000, 1'b1);
    send_request(32'h0000_0007, 1'b0);
    send_request(32'hFFFF_0000, 1'b0);
    send_request(32'h0000_FFFF, 1'b1);
  endtask

  // A window write in the middle of a block keeps the block; the shrunken window closes it
  // on the next sample and the mean divides by the new window.
  task automatic test_window_change();
    set_windows(8'd4, 8'd4);
    send_request(32'h0010_0000, 1'b0);
    send_request(32'h0020_0001, 1'b0);
    set_windows(8'd2, 8'd8);
    send_request(32'h0030_0002, 1'b0);
    send_request(32'h0000_0003, 1'b1);
  endtask

  // Three full-scale samples under a window of four, then the window shrinks, so the
  // quotient no longer fits the sample range and must saturate.
  task automatic test_mean_saturation();
    set_windows(8'd4, 8'd4);
    repeat (3) send_request(MAX_SAMPLE, 1'b0);
    set_windows(8'd1, 8'd2);
    send_request(MAX_SAMPLE, 1'b1);
  endtask

  // One phase of random traffic under fixed windows. eos_odds gives the chance of an end of
  // series as one in eos_odds, so series of random length and content are cut off at random.
  task automatic run_phase(input logic [WINDOW_BITS-1:0] first_len,
                           input logic [WINDOW_BITS-1:0] second_len,
                           input int count, input int eos_odds, input bit steady);
    set_windows(first_len, second_len);
    quiet = steady;
    for (int i = 0; i < count; i++) begin
      send_request(pick_sample(), $urandom_range(1, eos_odds) == 1);
    end
    drain();
    quiet = 1'b0;
  endtask

  // Random traffic across several settings, the window extremes among them. Each phase keeps
  // whatever blocks the previous one left open, so window changes land mid-block too.
  task automatic test_random_traffic();
    run_phase(8'd1, 8'd1, 100, 8, 1'b0);
    run_phase(8'd255, 8'd255, 480, 600, 1'b0);
    run_phase(8'd1, 8'd2, 120, 10, 1'b1);
    for (int p = 0; p < 4; p++) begin
      run_phase(WINDOW_BITS'($urandom_range(1, 9)), WINDOW_BITS'($urandom_range(1, 9)),
                80, 12, 1'b0);
    end
    run_phase(8'd255, 8'd1, 130, 300, 1'b0);
  endtask

  // The result side stalls now and then, mostly briefly.
  always @(posedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(9, 44);
      rdy = 1'b0;
    end
    out_ready <= rdy;
  end

  // Compares every accepted result with the oldest owed mean, field by field.
  always @(posedge clk) begin
    block_mean_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        $display("%0t: result with nothing owed: which_window %0d mean %h last %0d",
                 $time, which_window, mean, last);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        means_checked++;
        if (which_window !== want.which_window) begin
          $display("%0t: which_window expected %0d actual %0d",
                   $time, want.which_window, which_window);
          mismatches++;
        end
        if (mean !== want.mean) begin
          $display("%0t: mean expected %h actual %h", $time, want.mean, mean);
          mismatches++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, last);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if neither a request nor a result is taken for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d means still owed",
                 $time, STALL_LIMIT, pending_means.size());
        $display("tb_dual_window_block_mean_core NOT OK");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k < 2; k++) begin
      win_len[k] = WINDOW_BITS'(1);
      blk_cnt[k] = '0;
      blk_sum[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_windows();
    test_zero_window();
    test_end_of_series();
    test_window_change();
    test_mean_saturation();
    test_random_traffic();
    drain();

    $display("Sent %0d requests under %0d window settings; checked %0d means, %0d saturated.",
             requests_sent, settings_used, means_checked, saturated);
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("tb_dual_window_block_mean_core OK");
    end else begin
      $display("tb_dual_window_block_mean_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dwbm_pkg.sv
sv/dwbm_ctrl.sv
sv/dwbm_datapath.sv
sv/dual_window_block_mean_core.sv
bench/tb_dual_window_block_mean_core.sv
